// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and the alphabet lookup for the Base64 encoder.
package b64e_pkg;

  // ASCII code of the '=' padding character
  localparam logic [7:0] PAD_CODE = 8'd61;

  // Position within the current 3-byte group
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  // One classified byte: up to four characters, index of the last one,
  // and whether the last one closes the message
  typedef struct packed {
    logic [3:0][7:0] code;
    logic [1:0]      last_idx;
    logic            last;
  } job_t;

  // Map a sextet to its character of the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    priority if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      r = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// Front end: accepts bytes, tracks the group phase and builds character jobs.
module b64e_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    data_byte,
  input  logic          final_byte,
  input  logic          q_full,
  output logic          q_push,
  output b64e_pkg::job_t job
);

  b64e_pkg::phase_t phase, phase_next;
  logic [3:0] kept, kept_next;

  assign q_push = push && !q_full;

  // Hold phase and leftover bits; advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= b64e_pkg::PH_0;
      kept  <= 4'd0;
    end else if (q_push) begin
      phase <= phase_next;
      kept  <= kept_next;
    end
  end

  // Classify the byte into its characters and the next phase
  always_comb begin
    job.code     = '{default: b64e_pkg::PAD_CODE};
    job.last_idx = 2'd0;
    job.last     = final_byte;
    phase_next   = b64e_pkg::PH_0;
    kept_next    = 4'd0;
    unique case (phase)
      b64e_pkg::PH_1: begin
        job.code[0] = b64e_pkg::b64_char({kept[1:0], data_byte[7:4]});
        if (final_byte) begin
          job.code[1]  = b64e_pkg::b64_char({data_byte[3:0], 2'b00});
          job.last_idx = 2'd2;
        end else begin
          phase_next = b64e_pkg::PH_2;
          kept_next  = data_byte[3:0];
        end
      end
      b64e_pkg::PH_2: begin
        job.code[0]  = b64e_pkg::b64_char({kept, data_byte[7:6]});
        job.code[1]  = b64e_pkg::b64_char(data_byte[5:0]);
        job.last_idx = 2'd1;
      end
      default: begin
        job.code[0] = b64e_pkg::b64_char(data_byte[7:2]);
        if (final_byte) begin
          job.code[1]  = b64e_pkg::b64_char({data_byte[1:0], 4'b0000});
          job.last_idx = 2'd3;
        end else begin
          phase_next = b64e_pkg::PH_1;
          kept_next  = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

endmodule

// ===== rtl/b64e_queue.sv =====
// Short job queue between the front end and the character serializer.
module b64e_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  b64e_pkg::job_t wr_data,
  input  logic           rd_en,
  output b64e_pkg::job_t rd_data,
  output logic           valid,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign valid   = (count != '0);
  assign full    = (count == CW'(DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = slots[rd_ptr];

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: plays out one character per cycle into an output register unless the receiver stalls.
module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  b64e_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_pop,
  output logic [7:0]     char_code,
  output logic           end_of_text,
  output logic           empty,
  input  logic           pop
);

  b64e_pkg::job_t cur;
  logic           cur_valid;
  logic [1:0]     idx;
  logic           out_valid;
  logic           advance;
  logic           at_last;

  assign empty   = !out_valid;
  assign advance = !out_valid || pop;
  assign at_last = (idx == cur.last_idx);
  assign job_pop = job_valid && (!cur_valid || (advance && at_last));

  // Load the next job and step through its characters
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (job_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (cur_valid && advance) begin
      if (at_last) begin
        cur_valid <= 1'b0;
      end
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
  end

  // Output register: refill when drained or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cur_valid) begin
      char_code   <= cur.code[idx];
      end_of_text <= cur.last && at_last;
    end
  end

endmodule

// ===== rtl/base64_encoder_unit.sv =====
// Streaming Base64 encoder (standard alphabet, '=' padding).
//
// Input channel: one message byte per word on data_byte, with final_byte set
// on the last byte of the message. A word is taken when push is high and full
// is low. Result channel: one ASCII character per word on char_code; the last
// character of a message has end_of_text set. A word is shown while empty is
// low and leaves when pop is high.
//
// A byte yields one or two characters, and a last byte up to four (the
// closing character and '=' padding). The front end classifies a byte in the
// cycle it is accepted and writes a job into a QUEUE_DEPTH-entry queue; the
// back end plays one character per cycle into the output register while the
// receiver keeps popping. An accepted byte passes through the queue and the
// back end's job register before its first character shows. The output
// register sets the rate, and the queue takes further bytes while earlier
// ones play out; a last byte that opens a new group yields 4 characters.
//
// Reset clears the group phase, the queue and the output register. When the
// receiver stalls, the output word holds, the queue fills and full rises;
// nothing is dropped.
module base64_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_code,
  output logic       end_of_text
);

  b64e_pkg::job_t wr_job, rd_job;
  logic           q_push, q_valid, q_pop;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (full),
    .q_push     (q_push),
    .job        (wr_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (wr_job),
    .rd_en   (q_pop),
    .rd_data (rd_job),
    .valid   (q_valid),
    .full    (full)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (rd_job),
    .job_valid   (q_valid),
    .job_pop     (q_pop),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .empty       (empty),
    .pop         (pop)
  );

  // Reset drains both sides
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("encoder not cleared after reset");

  // A first pad character is followed at once by the closing pad
  a_pad_pair: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && char_code == b64e_pkg::PAD_CODE && !end_of_text) |=>
      (!empty && char_code == b64e_pkg::PAD_CODE && end_of_text))
    else $error("padding sequence broken");

  // The back end never pops a job from an empty queue
  a_job_move: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !q_valid) |-> 1'b0)
    else $error("job taken from an empty queue");

endmodule
